// ----- sv/ray_voxel_traversal_core_assert.svh -----
// assertion macros for the voxel traversal core
// used by the top level only, needs nothing else
`ifndef RAY_VOXEL_TRAVERSAL_CORE_ASSERT_SVH
`define RAY_VOXEL_TRAVERSAL_CORE_ASSERT_SVH

// same-cycle implication
`define RVT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("voxel traversal check failed");

// next-cycle implication
`define RVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("voxel traversal check failed");

`endif

// ----- sv/rvt_pkg.sv -----
// shared types and constants for the voxel traversal core
// no dependencies
`timescale 1ns / 1ps

package rvt_pkg;

   localparam int COORD_BITS = 16;
   localparam int CELL_OUT_W = 16;
   localparam int CELL_W = 18;
   localparam int EDGE_W = 15;
   localparam int T_W = 48;
   localparam int T_FRAC = 32;
   localparam int DEN_W = 16;
   localparam int NB_W = 6;
   localparam int MAX_STEPS_DEF = 64;
   localparam logic [EDGE_W-1:0] EDGE_RESET = 15'd256;
   localparam logic [T_W-1:0] T_SAT = {T_W{1'b1}};

   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_START_X = 4'd0;
   localparam logic [OP_W-1:0] OP_TGT_X = 4'd3;
   localparam logic [OP_W-1:0] OP_SPAC_X = 4'd6;
   localparam logic [OP_W-1:0] OP_NEXT_X = 4'd9;
   localparam logic [OP_W-1:0] OP_LAST = 4'd11;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_store;
      logic walk_emit;
      logic [OP_W-1:0] op;
   } rvt_cmd_type;

   typedef struct packed {
      logic div_done;
      logic walk_last;
   } rvt_status_type;

endpackage

// ----- sv/ray_voxel_traversal_core.sv -----
// 3-D voxel walk of one ray segment, grid stepping in amanatides-woo order
// a ray beat first runs the set-up divisions on the bit-serial divider
// then one voxel beat per cycle while the result side takes them
// a new ray is taken only once the walk has emitted the last voxel of the previous ray
// reset: synchronous active-high, clears control state, voxel edge back to 256
`timescale 1ns / 1ps

module ray_voxel_traversal_core #(
   parameter int MAX_STEPS = rvt_pkg::MAX_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // ray beat
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z (16 bits each)
   input  logic [6*rvt_pkg::COORD_BITS-1:0]  req_tdata,
   // voxel beat
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cell_x, cell_y, cell_z (16 bits each)
   output logic [3*rvt_pkg::CELL_OUT_W-1:0]  rsp_tdata,
   // terminal flag, voxel holds the end point
   output logic                              rsp_tuser,
   // last_of_ray
   output logic                              rsp_tlast,
   // voxel edge register
   input  logic                              csr_we,
   input  logic [rvt_pkg::EDGE_W-1:0]        csr_wdata
);
   import rvt_pkg::*;

   rvt_cmd_type    cmd;
   rvt_status_type status;

   // controller: set-up sequence over the shared divider, then walk
   rvt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // datapath: ray registers, divider, crossing parameters, result register
   rvt_datapath #(
      .MAX_STEPS (MAX_STEPS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .coords    (req_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .out_cells (rsp_tdata),
      .out_term  (rsp_tuser),
      .out_last  (rsp_tlast)
   );

`include "ray_voxel_traversal_core_assert.svh"

   // a ray beat is followed by a busy input side
   `RVT_ASSERT_NEXT(a_busy_after_ray, clock, reset, req_tvalid && req_tready, !req_tready)
   // a held voxel beat is never overwritten
   `RVT_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.walk_emit, !rsp_tvalid || rsp_tready)
   // a terminal voxel always closes the ray
   `RVT_ASSERT_NOW(a_term_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)

endmodule

// ----- sv/rvt_div.sv -----
// restoring divider, one quotient bit per cycle
// uses rvt_pkg
`timescale 1ns / 1ps

module rvt_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rvt_pkg::T_W-1:0]     dividend,
   input  logic [rvt_pkg::DEN_W-1:0]   divisor,
   input  logic [rvt_pkg::NB_W-1:0]    nbits,
   output logic [rvt_pkg::T_W-1:0]     quotient,
   output logic [rvt_pkg::DEN_W-1:0]   remainder,
   output logic                        done
);
   import rvt_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [NB_W-1:0]  cnt_ff, cnt_in;
   logic [T_W-1:0]   dvd_ff, dvd_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem2;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      rem2 = {rem_ff, dvd_ff[T_W-1]};
      diff = rem2 - {1'b0, den_ff};
      ge = (rem2 >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = nbits;
         dvd_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
         dvd_in = {dvd_ff[T_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == NB_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = dvd_ff;
   assign remainder = rem_ff;
   assign done = done_ff;

endmodule

// ----- sv/rvt_datapath.sv -----
// ray set-up, walk registers and result payload
// uses rvt_pkg and rvt_div
`timescale 1ns / 1ps

module rvt_datapath #(
   parameter int MAX_STEPS = rvt_pkg::MAX_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rvt_pkg::rvt_cmd_type              cmd,
   output rvt_pkg::rvt_status_type           status,
   input  logic [6*rvt_pkg::COORD_BITS-1:0]  coords,
   input  logic                              csr_we,
   input  logic [rvt_pkg::EDGE_W-1:0]        csr_wdata,
   output logic [3*rvt_pkg::CELL_OUT_W-1:0]  out_cells,
   output logic                              out_term,
   output logic                              out_last
);
   import rvt_pkg::*;

   localparam int CNT_W = $clog2(MAX_STEPS + 1);

   logic [EDGE_W-1:0]            edge_ff, edge_in;
   logic [EDGE_W-1:0]            vs;
   logic signed [COORD_BITS-1:0] s_ff [3];
   logic signed [COORD_BITS-1:0] e_ff [3];
   logic [CELL_W-1:0]            cur_ff [3];
   logic [CELL_W-1:0]            tgt_ff [3];
   logic [EDGE_W-1:0]            rf_ff [3];
   logic [T_W-1:0]               nb_ff [3];
   logic [T_W-1:0]               sp_ff [3];
   logic [2:0]                   dir_ff, mov_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [CELL_OUT_W-1:0]        oc_ff [3];
   logic                         term_ff, last_ff;

   logic [16:0]       d [3];
   logic [15:0]       ad [3];
   logic [1:0]        ax;
   logic signed [COORD_BITS-1:0] v;
   logic [16:0]       mag;
   logic [T_W-1:0]    dividend;
   logic [DEN_W-1:0]  divisor;
   logic [NB_W-1:0]   nbits;
   logic [EDGE_W-1:0] face_dist;
   logic [T_W-1:0]    quo;
   logic [DEN_W-1:0]  rem;
   logic              div_done;
   logic              r_nz;
   logic [CELL_W-1:0] qe, cell_idx;
   logic [EDGE_W-1:0] rf;

   logic              term, limit, found, last;
   logic [1:0]        best;
   logic [T_W:0]      tsum;

   assign edge_in = csr_we ? csr_wdata : edge_ff;
   assign vs = (edge_ff == '0) ? EDGE_W'(1) : edge_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         d[a] = {e_ff[a][COORD_BITS-1], e_ff[a]} - {s_ff[a][COORD_BITS-1], s_ff[a]};
         ad[a] = d[a][16] ? 16'(17'd0 - d[a]) : d[a][15:0];
      end
   end

   // operand selection for the shared divider
   always_comb begin
      if (cmd.op < OP_TGT_X)
         ax = cmd.op[1:0];
      else if (cmd.op < OP_SPAC_X)
         ax = 2'(cmd.op - OP_TGT_X);
      else if (cmd.op < OP_NEXT_X)
         ax = 2'(cmd.op - OP_SPAC_X);
      else
         ax = 2'(cmd.op - OP_NEXT_X);
      v = (cmd.op < OP_TGT_X) ? s_ff[ax] : e_ff[ax];
      mag = v[COORD_BITS-1] ? (17'd0 - {v[COORD_BITS-1], v}) : {v[COORD_BITS-1], v};
      face_dist = dir_ff[ax] ? rf_ff[ax] : (vs - rf_ff[ax]);
      if (cmd.op < OP_SPAC_X) begin
         dividend = {mag, 31'd0};
         divisor = DEN_W'(vs);
         nbits = NB_W'(17);
      end else if (cmd.op < OP_NEXT_X) begin
         dividend = {1'b0, vs, 32'd0};
         divisor = ad[ax];
         nbits = NB_W'(T_W);
      end else begin
         dividend = {1'b0, face_dist, 32'd0};
         divisor = ad[ax];
         nbits = NB_W'(T_W);
      end
      r_nz = (rem != '0);
      qe = CELL_W'(quo[16:0]) + CELL_W'(v[COORD_BITS-1] & r_nz);
      cell_idx = v[COORD_BITS-1] ? (CELL_W'(0) - qe) : qe;
      rf = (v[COORD_BITS-1] && r_nz) ? (vs - rem[EDGE_W-1:0]) : rem[EDGE_W-1:0];
   end

   rvt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dividend),
      .divisor   (divisor),
      .nbits     (nbits),
      .quotient  (quo),
      .remainder (rem),
      .done      (div_done)
   );

   // walk decision: smallest next crossing, x before y before z on a tie
   always_comb begin
      term = (cur_ff[0] == tgt_ff[0]) && (cur_ff[1] == tgt_ff[1]) &&
             (cur_ff[2] == tgt_ff[2]);
      limit = ({1'b0, cnt_ff} + 1'b1) >= (CNT_W + 1)'(MAX_STEPS);
      found = mov_ff[0];
      best = 2'd0;
      if (mov_ff[1] && (!found || nb_ff[1] < nb_ff[best])) begin
         best = 2'd1;
         found = 1'b1;
      end
      if (mov_ff[2] && (!found || nb_ff[2] < nb_ff[best])) begin
         best = 2'd2;
         found = 1'b1;
      end
      last = term || limit || !found;
      tsum = {1'b0, nb_ff[best]} + {1'b0, sp_ff[best]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff <= EDGE_RESET;
      end else begin
         edge_ff <= edge_in;
      end
      if (cmd.load) begin
         for (int a = 0; a < 3; a++) begin
            s_ff[a] <= coords[a*COORD_BITS +: COORD_BITS];
            e_ff[a] <= coords[(a+3)*COORD_BITS +: COORD_BITS];
         end
         cnt_ff <= '0;
      end
      if (cmd.div_store) begin
         if (cmd.op < OP_TGT_X) begin
            cur_ff[ax] <= cell_idx;
            rf_ff[ax] <= rf;
            dir_ff[ax] <= d[ax][16];
            mov_ff[ax] <= (d[ax] != '0);
         end else if (cmd.op < OP_SPAC_X) begin
            tgt_ff[ax] <= cell_idx;
         end else if (cmd.op < OP_NEXT_X) begin
            sp_ff[ax] <= mov_ff[ax] ? quo : T_SAT;
         end else begin
            nb_ff[ax] <= mov_ff[ax] ? quo : T_SAT;
         end
      end
      if (cmd.walk_emit) begin
         for (int a = 0; a < 3; a++)
            oc_ff[a] <= cur_ff[a][CELL_OUT_W-1:0];
         term_ff <= term;
         last_ff <= last;
         cnt_ff <= cnt_ff + 1'b1;
         if (!last) begin
            cur_ff[best] <= dir_ff[best] ? (cur_ff[best] - 1'b1) : (cur_ff[best] + 1'b1);
            nb_ff[best] <= tsum[T_W] ? T_SAT : tsum[T_W-1:0];
         end
      end
   end

   assign status.div_done = div_done;
   assign status.walk_last = last;
   assign out_cells = {oc_ff[2], oc_ff[1], oc_ff[0]};
   assign out_term = term_ff;
   assign out_last = last_ff;

endmodule

// ----- sv/rvt_ctrl.sv -----
// sequencer for set-up divisions and the voxel walk
// uses rvt_pkg
`timescale 1ns / 1ps

module rvt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output rvt_pkg::rvt_cmd_type    cmd,
   input  rvt_pkg::rvt_status_type status
);
   import rvt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_WALK
   } state_type;

   state_type       state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic            vld_ff, vld_in;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      cmd = '0;
      cmd.op = op_ff;
      vld_in = vld_ff & ~rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               op_in = OP_START_X;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               if (op_ff == OP_LAST) begin
                  state_in = ST_WALK;
               end else begin
                  op_in = op_ff + 1'b1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_WALK: begin
            if (!vld_ff || rsp_tready) begin
               cmd.walk_emit = 1'b1;
               vld_in = 1'b1;
               if (status.walk_last)
                  state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff <= OP_START_X;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         vld_ff <= vld_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = vld_ff;

endmodule
